// ===== src/assert_macros.svh =====
// Assertion macros shared by the date stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define CDS_ASSERT_NEVER(lbl, expr, msg) \
  `CDS_ASSERT(lbl, !(expr), msg)

`endif

// ===== src/cds_pkg.sv =====
// Types, constants and calendar table functions for the date stepper.
package cds_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned OrdinalW = 9;

  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;

  // Multiplicative inverse of 25 modulo 2**14, and the largest product that
  // still marks a multiple of 25 (floor((2**14 - 1) / 25)).
  localparam logic [YearW-1:0] Inv25     = 14'd7209;
  localparam logic [YearW-1:0] Div25Max  = 14'd655;

  typedef enum logic [1:0] {
    ActLoad     = 2'd0,
    ActAddDay   = 2'd1,
    ActAddMonth = 2'd2,
    ActAddYear  = 2'd3
  } action_e;

  // Gregorian leap rule. Divisibility by 25 uses the exact inverse test for
  // an odd divisor, so no divider is needed. Only the low bits of the
  // product matter for that test.
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [YearW-1:0] prod;
    logic             div4;
    logic             div16;
    logic             div25;
    prod  = year * Inv25;
    div4  = (year[1:0] == 2'd0);
    div16 = (year[3:0] == 4'd0);
    div25 = (prod <= Div25Max);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic leap,
                                                input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [OrdinalW-1:0] days_before(input logic leap,
                                                      input logic [MonthW-1:0] month);
    logic [OrdinalW-1:0] base;
    logic [OrdinalW-1:0] extra;
    unique case (month)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    extra = (leap && (month > 4'd2)) ? 9'd1 : 9'd0;
    return base + extra;
  endfunction

endpackage

// ===== src/calendar_date_stepper.sv =====
// Gregorian date stepper: kept date register with load and add-day/month/year steps.
//
// The block keeps one Gregorian date, starting at January 1 of year 1 after
// reset. Every item on the input stream either loads a date (tuser = 0) or
// advances the kept date by one day (1), one month (2) or one year (3), and
// every item yields exactly one result item carrying the new date and its day
// of year (1 to 366, leap aware). Loaded values are clamped: a year above
// MAX_YEAR becomes MAX_YEAR, month 0 becomes 1 and months above 12 become 12,
// and day 0 becomes 1 while a day past the month end becomes the last day of
// that month. Adding a day past the month end gives the 1st of the next month;
// adding a month or a year clamps the day to the last day of the new month,
// so February 29 plus one year gives February 28. Stepping past December goes
// to January of the next year, and stepping past MAX_YEAR wraps to year 0.
// Year 0 counts as a leap year. An item is latched into an input register and
// moves on into the result register once that register is free, and a new
// item can be taken every cycle while the result stream does not stall. The
// logic between the two registers holds one small multiplier (the
// divisibility-by-25 check of the leap rule) followed by the month-length
// lookups, the day clamp and the day-of-year add. When the result stream
// stalls, the input register holds one more item and then the input side
// stops taking items.
module calendar_date_stepper #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: load_year [13:0], load_month [17:14], load_day [22:18], zeros [23]
  input  logic [23:0] s_axis_tdata,
  // tuser: action [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cur_year [13:0], cur_month [17:14], cur_day [22:18], ordinal_day [31:23]
  output logic [31:0] m_axis_tdata
);

  `include "assert_macros.svh"

  localparam logic [cds_pkg::YearW-1:0] MaxYr = cds_pkg::YearW'(MAX_YEAR);

  // Input register.
  logic                          in_valid_q;
  cds_pkg::action_e              in_action_q;
  logic [cds_pkg::YearW-1:0]     in_year_q;
  logic [cds_pkg::MonthW-1:0]    in_month_q;
  logic [cds_pkg::DayW-1:0]      in_day_q;

  // Kept date, plus the leap flag of the kept year.
  logic [cds_pkg::YearW-1:0]     year_q,  year_d;
  logic [cds_pkg::MonthW-1:0]    month_q, month_d;
  logic [cds_pkg::DayW-1:0]      day_q,   day_d;
  logic                          leap_q,  leap_d;

  // Result register.
  logic                          out_valid_q;
  logic [cds_pkg::YearW-1:0]     out_year_q;
  logic [cds_pkg::MonthW-1:0]    out_month_q;
  logic [cds_pkg::DayW-1:0]      out_day_q;
  logic [cds_pkg::OrdinalW-1:0]  out_ord_q, ord_d;

  logic                          s_accept;
  logic                          out_free;
  logic                          step_en;

  logic [cds_pkg::YearW-1:0]     year_inc;
  logic [cds_pkg::YearW-1:0]     load_year;
  logic [cds_pkg::MonthW-1:0]    load_month;
  logic [cds_pkg::YearW-1:0]     cand_year;
  logic                          leap_cand;
  logic [cds_pkg::DayW-1:0]      cur_len;
  logic [cds_pkg::DayW-1:0]      new_len;

  // Checked conditions.
  logic                          out_is_kept;
  logic                          out_day_ok;
  logic                          kept_in_range;
  logic                          pipe_full;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ord_q, out_day_q, out_month_q, out_year_q};

  always_comb begin
    year_inc   = (year_q >= MaxYr) ? '0 : year_q + 14'd1;
    load_year  = (in_year_q > MaxYr) ? MaxYr : in_year_q;
    if (in_month_q == 4'd0) begin
      load_month = 4'd1;
    end else if (in_month_q > cds_pkg::MonthsPerYear) begin
      load_month = cds_pkg::MonthsPerYear;
    end else begin
      load_month = in_month_q;
    end

    // Only one year other than the kept one can arise per item: the loaded
    // year for a load, the following year for every step.
    cand_year = (in_action_q == cds_pkg::ActLoad) ? load_year : year_inc;
    leap_cand = cds_pkg::is_leap(cand_year);
    cur_len   = cds_pkg::month_len(leap_q, month_q);

    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    leap_d  = leap_q;

    unique case (in_action_q)
      cds_pkg::ActLoad: begin
        year_d  = load_year;
        month_d = load_month;
        day_d   = in_day_q;
        leap_d  = leap_cand;
      end
      cds_pkg::ActAddDay: begin
        if (day_q >= cur_len) begin
          day_d = 5'd1;
          if (month_q == cds_pkg::MonthsPerYear) begin
            month_d = 4'd1;
            year_d  = year_inc;
            leap_d  = leap_cand;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d = day_q + 5'd1;
        end
      end
      cds_pkg::ActAddMonth: begin
        if (month_q == cds_pkg::MonthsPerYear) begin
          month_d = 4'd1;
          year_d  = year_inc;
          leap_d  = leap_cand;
        end else begin
          month_d = month_q + 4'd1;
        end
      end
      cds_pkg::ActAddYear: begin
        year_d = year_inc;
        leap_d = leap_cand;
      end
      default: begin
        year_d = year_q;
      end
    endcase

    // Clamp the day into the new month; only a load can bring day 0.
    new_len = cds_pkg::month_len(leap_d, month_d);
    if (day_d > new_len) begin
      day_d = new_len;
    end
    if (day_d == 5'd0) begin
      day_d = 5'd1;
    end

    ord_d = cds_pkg::days_before(leap_d, month_d) + cds_pkg::OrdinalW'(day_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      year_q      <= 14'd1;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      leap_q      <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end

      if (step_en) begin
        out_valid_q <= 1'b1;
        year_q      <= year_d;
        month_q     <= month_d;
        day_q       <= day_d;
        leap_q      <= leap_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_action_q <= cds_pkg::action_e'(s_axis_tuser);
      in_year_q   <= s_axis_tdata[13:0];
      in_month_q  <= s_axis_tdata[17:14];
      in_day_q    <= s_axis_tdata[22:18];
    end
    if (step_en) begin
      out_year_q  <= year_d;
      out_month_q <= month_d;
      out_day_q   <= day_d;
      out_ord_q   <= ord_d;
    end
  end

  assign out_is_kept   = (out_year_q == year_q) && (out_month_q == month_q) &&
                         (out_day_q == day_q);
  assign out_day_ok    = (out_day_q != 5'd0) &&
                         (out_day_q <= cds_pkg::month_len(cds_pkg::is_leap(out_year_q),
                                                          out_month_q));
  assign kept_in_range = (year_q <= MaxYr) && (month_q != 4'd0) &&
                         (month_q <= cds_pkg::MonthsPerYear);
  assign pipe_full     = in_valid_q && out_valid_q && !m_axis_tready;

  `CDS_ASSERT(a_out_matches_state, m_axis_tvalid |-> out_is_kept, "result differs from kept date")
  `CDS_ASSERT(a_ready_only_on_stall, pipe_full || s_axis_tready, "input stalled, pipe not full")
  `CDS_ASSERT_NEVER(a_day_in_month, m_axis_tvalid && !out_day_ok, "day outside its month")
  `CDS_ASSERT(a_process_gives_result, step_en |=> m_axis_tvalid, "item produced no result")
  `CDS_ASSERT(a_year_in_range, kept_in_range, "kept date out of range")

endmodule
